// ===== rtl/core/bbs_pkg.sv =====
package bbs_pkg;

    localparam int SAMPLE_BITS = 10;
    localparam int CFG_BITS    = 16;
    localparam int BLOCK_BITS  = 4;
    localparam int SUM_BITS    = SAMPLE_BITS + BLOCK_BITS;
    localparam int PROD_BITS   = SAMPLE_BITS + CFG_BITS;
    localparam int STEP_BITS   = $clog2(PROD_BITS);

    localparam int IN_TDATA_BITS  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_FIELD_BITS = 3 * SAMPLE_BITS + CFG_BITS + 2;
    localparam int OUT_TDATA_BITS = ((OUT_FIELD_BITS + 7) / 8) * 8;

    localparam int CFG_IDX_BITS = 2;

    localparam logic [CFG_IDX_BITS-1:0] REG_REFERENCE = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_DIVIDER   = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_LOW_LIMIT = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] REG_HIGH_LIMIT = 2'd3;

    localparam logic [CFG_BITS-1:0] RESET_REFERENCE  = 16'd3300;
    localparam logic [CFG_BITS-1:0] RESET_DIVIDER    = 16'd1024;
    localparam logic [CFG_BITS-1:0] RESET_LOW_LIMIT  = 16'd3000;
    localparam logic [CFG_BITS-1:0] RESET_HIGH_LIMIT = 16'd4200;

    localparam logic [BLOCK_BITS-1:0] POS_DROP   = 4'h0;
    localparam logic [BLOCK_BITS-1:0] POS_FIRST  = 4'h1;
    localparam logic [BLOCK_BITS-1:0] POS_DOUBLE = 4'h3;
    localparam logic [BLOCK_BITS-1:0] POS_LAST   = 4'hf;

    localparam logic [STEP_BITS-1:0] DIV_LAST = STEP_BITS'(PROD_BITS - 1);

    typedef struct packed {
        logic mul;
        logic step;
        logic finish;
    } bbs_cmd_t;

    typedef struct packed {
        logic pend;
        logic out_free;
    } bbs_sts_t;

endpackage

// ===== rtl/core/bbs_ctrl.sv =====
module bbs_ctrl
    import bbs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  bbs_sts_t sts,
    output bbs_cmd_t cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0]           state_reg;
    logic [1:0]           state_next;
    logic [STEP_BITS-1:0] cnt_reg;
    logic [STEP_BITS-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (sts.pend)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                cnt_next   = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DIV_LAST)
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (sts.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== rtl/core/bbs_datapath.sv =====
module bbs_datapath
    import bbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data,
    input  bbs_cmd_t                  cmd,
    output bbs_sts_t                  sts
);

    logic [CFG_BITS-1:0]    ref_reg;
    logic [CFG_BITS-1:0]    div_reg;
    logic [CFG_BITS-1:0]    low_lim_reg;
    logic [CFG_BITS-1:0]    high_lim_reg;

    logic [BLOCK_BITS-1:0]  pos_reg;
    logic [BLOCK_BITS-1:0]  pos_next;
    logic                   pend_reg;
    logic                   pend_next;
    logic                   m_tvalid_reg;
    logic                   m_tvalid_next;
    logic                   low_seen_reg;
    logic                   low_seen_next;
    logic                   high_seen_reg;
    logic                   high_seen_next;

    logic [SUM_BITS-1:0]    sum_reg;
    logic [SUM_BITS-1:0]    sum_next;
    logic [SAMPLE_BITS-1:0] max_reg;
    logic [SAMPLE_BITS-1:0] max_next;
    logic [SAMPLE_BITS-1:0] min_reg;
    logic [SAMPLE_BITS-1:0] min_next;
    logic [SAMPLE_BITS-1:0] avg_hold_reg;
    logic [SAMPLE_BITS-1:0] avg_hold_next;
    logic [SAMPLE_BITS-1:0] peak_hold_reg;
    logic [SAMPLE_BITS-1:0] peak_hold_next;
    logic [SAMPLE_BITS-1:0] trough_hold_reg;
    logic [SAMPLE_BITS-1:0] trough_hold_next;
    logic [PROD_BITS-1:0]   work_reg;
    logic [PROD_BITS-1:0]   work_next;
    logic [CFG_BITS-1:0]    rem_reg;
    logic [CFG_BITS-1:0]    rem_next;

    logic [SAMPLE_BITS-1:0] avg_out_reg;
    logic [SAMPLE_BITS-1:0] avg_out_next;
    logic [SAMPLE_BITS-1:0] peak_out_reg;
    logic [SAMPLE_BITS-1:0] peak_out_next;
    logic [SAMPLE_BITS-1:0] trough_out_reg;
    logic [SAMPLE_BITS-1:0] trough_out_next;
    logic [CFG_BITS-1:0]    mv_out_reg;
    logic [CFG_BITS-1:0]    mv_out_next;

    logic                   accept;
    logic [SAMPLE_BITS-1:0] sample;
    logic [SUM_BITS-1:0]    sum_add;
    logic [SUM_BITS-1:0]    sum_new;
    logic [SAMPLE_BITS-1:0] max_new;
    logic [SAMPLE_BITS-1:0] min_new;
    logic [PROD_BITS-1:0]   product;
    logic [CFG_BITS:0]      partial;
    logic [CFG_BITS:0]      diff;
    logic                   fits;
    logic                   div_zero;
    logic                   is_low;
    logic                   is_high;

    assign sample   = s_tdata[SAMPLE_BITS-1:0];
    assign s_tready = !((pos_reg == POS_LAST) && pend_reg);
    assign accept   = s_tvalid && s_tready;

    assign sum_add = (pos_reg == POS_DOUBLE) ? SUM_BITS'({sample, 1'b0}) : SUM_BITS'(sample);
    assign sum_new = (pos_reg == POS_FIRST) ? SUM_BITS'(sample) : sum_reg + sum_add;
    assign max_new = ((pos_reg == POS_FIRST) || (sample > max_reg)) ? sample : max_reg;
    assign min_new = ((pos_reg == POS_FIRST) || (sample < min_reg)) ? sample : min_reg;

    assign product = PROD_BITS'(avg_hold_reg) * PROD_BITS'(ref_reg);

    // One restoring division step: shift in the next dividend bit and subtract if it fits.
    assign partial = {rem_reg, work_reg[PROD_BITS-1]};
    assign fits    = partial >= {1'b0, div_reg};
    assign diff    = partial - {1'b0, div_reg};

    // A zero divisor acts as a quotient above every limit.
    assign div_zero = (div_reg == '0);
    assign is_low   = !div_zero && (work_reg <= PROD_BITS'(low_lim_reg));
    assign is_high  = div_zero || (work_reg >= PROD_BITS'(high_lim_reg));

    always_comb
    begin
        pos_next         = pos_reg;
        pend_next        = pend_reg;
        sum_next         = sum_reg;
        max_next         = max_reg;
        min_next         = min_reg;
        avg_hold_next    = avg_hold_reg;
        peak_hold_next   = peak_hold_reg;
        trough_hold_next = trough_hold_reg;
        work_next        = work_reg;
        rem_next         = rem_reg;
        m_tvalid_next    = m_tvalid_reg;
        low_seen_next    = low_seen_reg;
        high_seen_next   = high_seen_reg;
        avg_out_next     = avg_out_reg;
        peak_out_next    = peak_out_reg;
        trough_out_next  = trough_out_reg;
        mv_out_next      = mv_out_reg;

        if (accept)
        begin
            pos_next = pos_reg + 1'b1;
            if (pos_reg != POS_DROP)
            begin
                sum_next = sum_new;
                max_next = max_new;
                min_next = min_new;
            end
            if (pos_reg == POS_LAST)
            begin
                avg_hold_next    = sum_new[SUM_BITS-1:BLOCK_BITS];
                peak_hold_next   = max_new;
                trough_hold_next = min_new;
                pend_next        = 1'b1;
            end
        end

        if (cmd.mul)
        begin
            work_next = product;
            rem_next  = '0;
        end

        if (cmd.step)
        begin
            rem_next  = fits ? diff[CFG_BITS-1:0] : partial[CFG_BITS-1:0];
            work_next = {work_reg[PROD_BITS-2:0], fits};
        end

        if (m_tready)
        begin
            m_tvalid_next = 1'b0;
        end

        if (cmd.finish)
        begin
            pend_next       = 1'b0;
            m_tvalid_next   = 1'b1;
            low_seen_next   = low_seen_reg || is_low;
            high_seen_next  = high_seen_reg || (!is_low && is_high);
            avg_out_next    = avg_hold_reg;
            peak_out_next   = peak_hold_reg;
            trough_out_next = trough_hold_reg;
            if (div_zero || (|work_reg[PROD_BITS-1:CFG_BITS]))
            begin
                mv_out_next = '1;
            end
            else
            begin
                mv_out_next = work_reg[CFG_BITS-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_reg       <= RESET_REFERENCE;
            div_reg       <= RESET_DIVIDER;
            low_lim_reg   <= RESET_LOW_LIMIT;
            high_lim_reg  <= RESET_HIGH_LIMIT;
            pos_reg       <= '0;
            pend_reg      <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            low_seen_reg  <= 1'b0;
            high_seen_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    REG_REFERENCE:  ref_reg      <= cfg_data;
                    REG_DIVIDER:    div_reg      <= cfg_data;
                    REG_LOW_LIMIT:  low_lim_reg  <= cfg_data;
                    REG_HIGH_LIMIT: high_lim_reg <= cfg_data;
                    default:        ref_reg      <= ref_reg;
                endcase
            end
            pos_reg       <= pos_next;
            pend_reg      <= pend_next;
            m_tvalid_reg  <= m_tvalid_next;
            low_seen_reg  <= low_seen_next;
            high_seen_reg <= high_seen_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg         <= sum_next;
        max_reg         <= max_next;
        min_reg         <= min_next;
        avg_hold_reg    <= avg_hold_next;
        peak_hold_reg   <= peak_hold_next;
        trough_hold_reg <= trough_hold_next;
        work_reg        <= work_next;
        rem_reg         <= rem_next;
        avg_out_reg     <= avg_out_next;
        peak_out_reg    <= peak_out_next;
        trough_out_reg  <= trough_out_next;
        mv_out_reg      <= mv_out_next;
    end

    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = OUT_TDATA_BITS'({high_seen_reg, low_seen_reg, mv_out_reg,
                                           trough_out_reg, peak_out_reg, avg_out_reg});
    assign sts.pend     = pend_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

`ifndef SYNTH
    a_finish_needs_pend: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> pend_reg)
        else $error("result finished with no block pending");

    a_finish_gives_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> m_tvalid_reg)
        else $error("finished result not presented");

    a_last_sets_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (pos_reg == POS_LAST)) |=> pend_reg)
        else $error("block end did not start a result");

    a_rem_below_div: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.step && !div_zero) |-> (rem_reg < div_reg))
        else $error("divider remainder out of range");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !cmd.finish)
        else $error("result overwritten while stalled");
`endif

endmodule

// ===== rtl/core/battery_block_stats_top.sv =====
// Channel  Direction  Payload
// s_       in         sample, one item per converter result, blocks of 16
// m_       out        average, peak, trough, millivolts, low and high battery flags
// cfg_     in         write-only registers: reference, divider, low limit, high limit
//
// Samples are taken one per cycle while s_tready is high; the 16th item of a block closes the block.
// The result is then made in order: the controller picks up the block end, a multiply
// step forms the product, the restoring divider gives one quotient bit per cycle, and a
// last step loads the output once m_ is free.
// The 16th item of the next block waits until that result is in the output register.
// A stall on m_ holds the result and, once the divider is done, the next block end.
// Reset is asynchronous, active low; the battery flags clear only on reset.
module battery_block_stats_top
    import bbs_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [IN_TDATA_BITS-1:0]  s_tdata,   // sample
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [OUT_TDATA_BITS-1:0] m_tdata,   // average, peak, trough, millivolts,
                                                 // low_battery, high_battery
    input  logic                      cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [CFG_BITS-1:0]       cfg_data
);

    bbs_cmd_t cmd;
    bbs_sts_t sts;

    bbs_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    bbs_datapath u_datapath
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
